@@ sv/websocket_frame_deframer_top_assert.svh @@
// assertion macros for the websocket deframer top level
// depends on nothing; included inside module bodies
`ifndef WEBSOCKET_FRAME_DEFRAMER_TOP_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define WSFD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define WSFD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/wsfd_pkg.sv @@
// shared types, codes and helpers of the websocket deframer
// no dependencies
package wsfd_pkg;

    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_ERROR   = 2'd2;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_IGNORED = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_PROTOCOL = 3'd1;
    localparam logic [2:0] ST_UNMASKED = 3'd2;
    localparam logic [2:0] ST_BAD_TEXT = 3'd3;
    localparam logic [2:0] ST_TOO_LONG = 3'd4;

    localparam logic [3:0] OP_CONT  = 4'd0;
    localparam logic [3:0] OP_TEXT  = 4'd1;
    localparam logic [3:0] OP_BIN   = 4'd2;
    localparam logic [3:0] OP_CLOSE = 4'd8;
    localparam logic [3:0] OP_PING  = 4'd9;
    localparam logic [3:0] OP_PONG  = 4'd10;

    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;
    localparam logic [6:0] CTRL_MAX_LEN = 7'd125;

    // second-byte limits of a utf-8 sequence
    localparam logic [2:0] U8_NONE = 3'd0;
    localparam logic [2:0] U8_A0BF = 3'd1;
    localparam logic [2:0] U8_809F = 3'd2;
    localparam logic [2:0] U8_90BF = 3'd3;
    localparam logic [2:0] U8_808F = 3'd4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload_byte;
        logic [31:0] payload_offset;
        logic        frame_done;
        logic [2:0]  status;
        logic [3:0]  frame_opcode;
        logic        final_flag;
        logic        compressed_flag;
        logic [31:0] frame_length;
        logic [15:0] close_code;
    } t_result;

    // queue head seen by the back end
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } t_q_head;

    function automatic logic close_code_ok(input logic [15:0] c);
        logic ok;
        ok = c inside {[16'd1000:16'd1003], [16'd1007:16'd1011], [16'd3000:16'd4999]};
        return ok;
    endfunction

endpackage

@@ sv/wsfd_ifs.sv @@
// stream and configuration channel interfaces of the websocket deframer
// depends on nothing
interface wsfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface wsfd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [31:0] payload_offset;
    logic        frame_done;
    logic [2:0]  status;
    logic [3:0]  frame_opcode;
    logic        final_flag;
    logic        compressed_flag;
    logic [31:0] frame_length;
    logic [15:0] close_code;
    modport source (output valid, output kind, output payload_byte, output payload_offset,
                    output frame_done, output status, output frame_opcode,
                    output final_flag, output compressed_flag, output frame_length,
                    output close_code, input ready);
    modport sink   (input valid, input kind, input payload_byte, input payload_offset,
                    input frame_done, input status, input frame_opcode,
                    input final_flag, input compressed_flag, input frame_length,
                    input close_code, output ready);
endinterface

interface wsfd_cfg_if;
    logic valid;
    logic ready;
    logic deflate_allowed;
    modport source (output valid, output deflate_allowed, input ready);
    modport sink   (input valid, input deflate_allowed, output ready);
endinterface

@@ sv/wsfd_front.sv @@
// front end: accepts raw words into a two-entry queue
// depends on wsfd_pkg
module wsfd_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [7:0]       i_data,
    output logic             o_ready,
    input  logic             i_pop,
    output wsfd_pkg::t_q_head o_head
);
    import wsfd_pkg::*;

    logic [7:0] r_slot [2];
    logic [1:0] r_count;
    logic       r_rd;
    logic       r_wr;
    logic       push;
    logic       pop;

    assign o_ready = (r_count != 2'd2);
    assign push    = i_valid && o_ready;
    assign pop     = i_pop && (r_count != 2'd0);
    assign o_head.valid = (r_count != 2'd0);
    assign o_head.data  = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
            r_rd    <= 1'b0;
            r_wr    <= 1'b0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            r_count <= r_count + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr] <= i_data;
        end
    end

endmodule

@@ sv/wsfd_back.sv @@
// back end: frame parser, unmasking, close checks and result register
// depends on wsfd_pkg
module wsfd_back #(
    parameter int LENGTH_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_deflate_allowed,
    input  wsfd_pkg::t_q_head i_head,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output wsfd_pkg::t_result o_result
);
    import wsfd_pkg::*;

    localparam int LB = LENGTH_BITS;

    logic [1:0]    r_phase, n_phase;
    logic [3:0]    r_hc, n_hc;
    logic [7:0]    r_fhb, n_fhb;
    logic [6:0]    r_lcode, n_lcode;
    logic [LB-1:0] r_acc, n_acc;
    logic          r_ovf, n_ovf;
    logic [31:0]   r_key, n_key;
    logic [LB-1:0] r_pcnt, n_pcnt;
    logic [15:0]   r_ccode, n_ccode;
    logic [1:0]    r_urem, n_urem;
    logic [2:0]    r_ulim, n_ulim;
    logic [2:0]    r_err, n_err;
    logic          r_valid;
    t_result       r_res, n_res;
    logic          step;

    assign step    = i_head.valid && (!r_valid || i_ready);
    assign o_pop   = step;
    assign o_valid = r_valid;
    assign o_result = r_res;

    always_comb begin
        logic [7:0]  b;
        logic [7:0]  pb;
        logic [3:0]  ext;
        logic [3:0]  op;
        logic        ctrl;
        logic        len_ready;
        logic        done;
        logic [2:0]  st;
        logic [1:0]  kind;
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic        u_ok;
        logic [63:0] acc64;
        logic [63:0] pc64;
        b  = i_head.data;
        n_phase = r_phase; n_hc = r_hc; n_fhb = r_fhb; n_lcode = r_lcode;
        n_acc = r_acc; n_ovf = r_ovf; n_key = r_key; n_pcnt = r_pcnt;
        n_ccode = r_ccode; n_urem = r_urem; n_ulim = r_ulim; n_err = r_err;
        pb = 8'd0; st = ST_OK; done = 1'b0; len_ready = 1'b0; kind = KIND_HEADER;
        lo = 8'h80; hi = 8'hBF; u_ok = 1'b1;
        ext = (r_lcode == LEN_CODE_16) ? 4'd2 : (r_lcode == LEN_CODE_64) ? 4'd8 : 4'd0;
        op = r_fhb[3:0];
        ctrl = (op == OP_CLOSE) || (op == OP_PING) || (op == OP_PONG);
        n_res = '0;
        case (r_phase)
            PH_HEADER: begin
                if (r_hc == 4'd0) begin
                    n_fhb = b; n_lcode = '0; n_acc = '0; n_ovf = 1'b0; n_key = '0;
                    n_pcnt = '0; n_ccode = '0; n_urem = '0; n_ulim = U8_NONE;
                    n_hc = 4'd1;
                end else if (r_hc == 4'd1) begin
                    n_lcode = b[6:0];
                    if (b[6:0] < LEN_CODE_16) begin
                        n_acc = LB'(b[6:0]);
                    end
                    n_hc = 4'd2;
                    len_ready = b[6:0] < LEN_CODE_16;
                    if (!((op <= OP_BIN) || ctrl)) st = ST_PROTOCOL;
                    else if (ctrl && (b[6:0] > CTRL_MAX_LEN || !r_fhb[7] || r_fhb[6]))
                        st = ST_PROTOCOL;
                    else if (r_fhb[5:4] != 2'd0) st = ST_PROTOCOL;
                    else if (r_fhb[6] && !i_deflate_allowed) st = ST_PROTOCOL;
                    else if (!b[7]) st = ST_UNMASKED;
                end else begin
                    if (r_hc < 4'd2 + ext) begin
                        if (r_acc[LB-1:LB-8] != 8'd0) n_ovf = 1'b1;
                        n_acc = {r_acc[LB-9:0], b};
                    end else begin
                        n_key = {r_key[23:0], b};
                    end
                    n_hc = r_hc + 4'd1;
                    len_ready = n_hc >= 4'd2 + ext;
                    if (n_hc >= 4'd6 + ext) begin
                        if (n_ovf) st = ST_TOO_LONG;
                        else if (op == OP_CLOSE && n_acc == LB'(1)) st = ST_PROTOCOL;
                        else if (n_acc == '0) begin
                            done = 1'b1; n_hc = 4'd0;
                        end else begin
                            n_phase = PH_PAYLOAD;
                        end
                    end
                end
            end
            PH_PAYLOAD: begin
                kind = KIND_PAYLOAD;
                len_ready = 1'b1;
                pb = b ^ r_key[31 - 8*r_pcnt[1:0] -: 8];
                if (op == OP_CLOSE) begin
                    if (r_pcnt == '0) begin
                        n_ccode = {pb, 8'd0};
                    end else if (r_pcnt == LB'(1)) begin
                        n_ccode = {r_ccode[15:8], pb};
                        if (!close_code_ok({r_ccode[15:8], pb})) st = ST_PROTOCOL;
                    end else begin
                        // utf-8 check of the close reason
                        if (r_urem != 2'd0) begin
                            case (r_ulim)
                                U8_A0BF: lo = 8'hA0;
                                U8_809F: hi = 8'h9F;
                                U8_90BF: lo = 8'h90;
                                U8_808F: hi = 8'h8F;
                                default: ;
                            endcase
                            if (pb < lo || pb > hi) u_ok = 1'b0;
                            else begin
                                n_ulim = U8_NONE; n_urem = r_urem - 2'd1;
                            end
                        end else begin
                            n_ulim = U8_NONE;
                            if (pb < 8'h80) u_ok = 1'b1;
                            else if (pb >= 8'hC2 && pb <= 8'hDF) n_urem = 2'd1;
                            else if (pb >= 8'hE0 && pb <= 8'hEF) begin
                                n_urem = 2'd2;
                                if (pb == 8'hE0) n_ulim = U8_A0BF;
                                else if (pb == 8'hED) n_ulim = U8_809F;
                            end else if (pb >= 8'hF0 && pb <= 8'hF4) begin
                                n_urem = 2'd3;
                                if (pb == 8'hF0) n_ulim = U8_90BF;
                                else if (pb == 8'hF4) n_ulim = U8_808F;
                            end else u_ok = 1'b0;
                        end
                        if (!u_ok) st = ST_BAD_TEXT;
                    end
                end
                n_pcnt = r_pcnt + LB'(1);
                if (st == ST_OK && n_pcnt == r_acc) begin
                    if (op == OP_CLOSE && n_urem != 2'd0) st = ST_BAD_TEXT;
                    else begin
                        done = 1'b1; n_phase = PH_HEADER; n_hc = 4'd0;
                    end
                end
            end
            default: begin
                kind = KIND_IGNORED;
                st = r_err;
            end
        endcase
        if (r_phase != PH_ERROR && st != ST_OK) begin
            n_err = st; n_phase = PH_ERROR; done = 1'b0;
        end
        acc64 = 64'(n_acc);
        pc64  = 64'(r_pcnt);
        n_res.kind            = kind;
        n_res.status          = st;
        n_res.frame_opcode    = n_fhb[3:0];
        n_res.final_flag      = n_fhb[7];
        n_res.compressed_flag = n_fhb[6];
        if (r_phase != PH_ERROR) begin
            n_res.payload_byte   = pb;
            n_res.payload_offset = (kind == KIND_PAYLOAD) ? pc64[31:0] : 32'd0;
            n_res.frame_done     = done;
            n_res.frame_length   = len_ready ? acc64[31:0] : 32'd0;
            n_res.close_code     = (n_fhb[3:0] == OP_CLOSE && n_pcnt >= LB'(2)) ?
                                   n_ccode : 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER; r_hc <= '0; r_fhb <= '0; r_lcode <= '0;
            r_acc <= '0; r_ovf <= 1'b0; r_key <= '0; r_pcnt <= '0;
            r_ccode <= '0; r_urem <= '0; r_ulim <= U8_NONE; r_err <= ST_OK;
            r_valid <= 1'b0;
        end else begin
            if (step) begin
                r_phase <= n_phase; r_hc <= n_hc; r_fhb <= n_fhb; r_lcode <= n_lcode;
                r_acc <= n_acc; r_ovf <= n_ovf; r_key <= n_key; r_pcnt <= n_pcnt;
                r_ccode <= n_ccode; r_urem <= n_urem; r_ulim <= n_ulim; r_err <= n_err;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_res <= n_res;
        end
    end

endmodule

@@ sv/websocket_frame_deframer_top.sv @@
// top level of the websocket frame deframer
// depends on wsfd_pkg, wsfd_ifs, wsfd_front, wsfd_back and the assertion header
//
// usage:
// - i_data carries the received client-to-server stream, one byte per word
// - o_result gives exactly one result word per input word, in order
// - i_cfg writes deflate_allowed; it is always ready, write it only when idle
// - a word is written into the input queue at its accepting edge, and the
//   parser later takes it from the queue head and registers its result
// - throughput is one word per cycle while the sink takes each result; the
//   parser step updates the header, length and unmask state for each byte
// - the two-entry input queue lets the source keep sending while the result
//   register waits; once it is full, i_data.ready drops until the sink takes
// - reset (i_rst_n low, synchronous) empties the queue, clears the result
//   valid flag, puts the parser in the header phase and clears deflate_allowed
// - errors are sticky: after one, every word yields an ignored result with
//   the same status until the next reset
module websocket_frame_deframer_top #(
    parameter int LENGTH_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    wsfd_in_if.sink       i_data,
    wsfd_cfg_if.sink      i_cfg,
    wsfd_out_if.source    o_result
);
    import wsfd_pkg::*;

    `include "websocket_frame_deframer_top_assert.svh"

    // configuration register
    logic    r_deflate_allowed;
    // queue head and pop between the two halves
    t_q_head q_head;
    logic    q_pop;
    t_result res;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deflate_allowed <= 1'b0;
        end else if (i_cfg.valid) begin
            r_deflate_allowed <= i_cfg.deflate_allowed;
        end
    end

    // front: accepts words and buffers them
    wsfd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_data.valid),
        .i_data  (i_data.data_byte),
        .o_ready (i_data.ready),
        .i_pop   (q_pop),
        .o_head  (q_head)
    );

    // back: parses, unmasks and holds the result word
    wsfd_back #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_deflate_allowed (r_deflate_allowed),
        .i_head            (q_head),
        .o_pop             (q_pop),
        .o_valid           (o_result.valid),
        .i_ready           (o_result.ready),
        .o_result          (res)
    );

    assign o_result.kind            = res.kind;
    assign o_result.payload_byte    = res.payload_byte;
    assign o_result.payload_offset  = res.payload_offset;
    assign o_result.frame_done      = res.frame_done;
    assign o_result.status          = res.status;
    assign o_result.frame_opcode    = res.frame_opcode;
    assign o_result.final_flag      = res.final_flag;
    assign o_result.compressed_flag = res.compressed_flag;
    assign o_result.frame_length    = res.frame_length;
    assign o_result.close_code      = res.close_code;

    // a completed frame never carries an error
    `WSFD_ASSERT_IMP(a_done_ok, i_clk, i_rst_n, o_result.valid && o_result.frame_done, o_result.status == ST_OK, "frame done with error status")
    // an ignored word always repeats a sticky error
    `WSFD_ASSERT_IMP(a_ignored_err, i_clk, i_rst_n, o_result.valid && o_result.kind == KIND_IGNORED, o_result.status != ST_OK, "ignored word without error")
    // a popped word always leaves a result in the next cycle
    `WSFD_ASSERT_NXT(a_pop_result, i_clk, i_rst_n, q_pop, o_result.valid, "popped word without result")

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// self-checking bench for websocket_frame_deframer_top: byte stream in, one result word out
// depends on wsfd_pkg, wsfd_ifs and the deframer rtl
module tb_top;
    import wsfd_pkg::*;

    logic i_clk;
    logic i_rst_n;

    wsfd_in_if  data_if ();
    wsfd_cfg_if cfg_if ();
    wsfd_out_if res_if ();

    websocket_frame_deframer_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_data   (data_if.sink),
        .i_cfg    (cfg_if.sink),
        .o_result (res_if.source)
    );

    always begin
        i_clk = 1'b1; #10;
        i_clk = 1'b0; #10;
    end

    // parser shadow state
    logic [1:0]  p_phase;
    logic [3:0]  p_hcnt;
    logic [7:0]  p_first;
    logic [6:0]  p_lcode;
    logic [31:0] p_len;
    logic        p_ovf;
    logic [31:0] p_key;
    logic [31:0] p_pcnt;
    logic [15:0] p_ccode;
    logic [1:0]  p_u8rem;
    logic [2:0]  p_u8lim;
    logic [2:0]  p_err;
    logic        p_deflate;

    t_result pending_results[$];
    int      mismatches;
    bit      quiet;

    function automatic bit utf8_accept(input logic [7:0] b);
        logic [7:0] lo, hi;
        if (p_u8rem != 0) begin
            lo = 8'h80;
            hi = 8'hBF;
            case (p_u8lim)
                U8_A0BF: lo = 8'hA0;
                U8_809F: hi = 8'h9F;
                U8_90BF: lo = 8'h90;
                U8_808F: hi = 8'h8F;
                default: ;
            endcase
            if (b < lo || b > hi) return 1'b0;
            p_u8lim = U8_NONE;
            p_u8rem = p_u8rem - 2'd1;
            return 1'b1;
        end
        p_u8lim = U8_NONE;
        if (b < 8'h80) return 1'b1;
        if (b >= 8'hC2 && b <= 8'hDF) begin
            p_u8rem = 2'd1;
            return 1'b1;
        end
        if (b >= 8'hE0 && b <= 8'hEF) begin
            p_u8rem = 2'd2;
            if (b == 8'hE0) p_u8lim = U8_A0BF;
            else if (b == 8'hED) p_u8lim = U8_809F;
            return 1'b1;
        end
        if (b >= 8'hF0 && b <= 8'hF4) begin
            p_u8rem = 2'd3;
            if (b == 8'hF0) p_u8lim = U8_90BF;
            else if (b == 8'hF4) p_u8lim = U8_808F;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [2:0] header_status(input logic [7:0] b1);
        logic [3:0] op;
        bit         ctrl;
        op   = p_first[3:0];
        ctrl = (op == OP_CLOSE) || (op == OP_PING) || (op == OP_PONG);
        if (!(op <= OP_BIN || ctrl)) return ST_PROTOCOL;
        if (ctrl && (b1[6:0] > CTRL_MAX_LEN || !p_first[7] || p_first[6])) return ST_PROTOCOL;
        if (p_first[5:4] != 2'b00) return ST_PROTOCOL;
        if (p_first[6] && !p_deflate) return ST_PROTOCOL;
        if (!b1[7]) return ST_UNMASKED;
        return ST_OK;
    endfunction

    function automatic bit valid_close_code(input logic [15:0] c);
        return (c >= 16'd1000 && c <= 16'd1003) || (c >= 16'd1007 && c <= 16'd1011) ||
               (c >= 16'd3000 && c <= 16'd4999);
    endfunction

    // advances the shadow parser by one stream byte and gives the result word
    function automatic t_result deframe_byte(input logic [7:0] b);
        t_result r;
        int      ext;
        bit      len_ready;
        logic [7:0] pb;
        r = '0;
        len_ready = 1'b0;
        if (p_phase == PH_ERROR) begin
            r.kind = KIND_IGNORED;
            r.status = p_err;
            r.frame_opcode = p_first[3:0];
            r.final_flag = p_first[7];
            r.compressed_flag = p_first[6];
            return r;
        end
        if (p_phase == PH_HEADER) begin
            r.kind = KIND_HEADER;
            if (p_hcnt == 0) begin
                p_first = b; p_lcode = '0; p_len = '0; p_ovf = 1'b0; p_key = '0;
                p_pcnt = '0; p_ccode = '0; p_u8rem = '0; p_u8lim = U8_NONE;
                p_hcnt = 4'd1;
            end else if (p_hcnt == 1) begin
                p_lcode = b[6:0];
                if (p_lcode < LEN_CODE_16) p_len = {25'd0, p_lcode};
                p_hcnt = 4'd2;
                r.status = header_status(b);
                len_ready = p_lcode < LEN_CODE_16;
            end else begin
                ext = (p_lcode == LEN_CODE_16) ? 2 : (p_lcode == LEN_CODE_64) ? 8 : 0;
                if (p_hcnt < 2 + ext) begin
                    if (p_len[31:24] != 0) p_ovf = 1'b1;
                    p_len = {p_len[23:0], b};
                end else begin
                    p_key = {p_key[23:0], b};
                end
                p_hcnt = p_hcnt + 4'd1;
                len_ready = p_hcnt >= 2 + ext;
                if (p_hcnt >= 6 + ext) begin
                    if (p_ovf) r.status = ST_TOO_LONG;
                    else if (p_first[3:0] == OP_CLOSE && p_len == 1) r.status = ST_PROTOCOL;
                    else if (p_len == 0) begin
                        r.frame_done = 1'b1;
                        p_hcnt = '0;
                    end else p_phase = PH_PAYLOAD;
                end
            end
        end else begin
            r.kind = KIND_PAYLOAD;
            len_ready = 1'b1;
            r.payload_offset = p_pcnt;
            pb = b ^ p_key[8*(3 - p_pcnt[1:0]) +: 8];
            r.payload_byte = pb;
            if (p_first[3:0] == OP_CLOSE) begin
                if (p_pcnt == 0) p_ccode = {pb, 8'h00};
                else if (p_pcnt == 1) begin
                    p_ccode[7:0] = pb;
                    if (!valid_close_code(p_ccode)) r.status = ST_PROTOCOL;
                end else if (!utf8_accept(pb)) r.status = ST_BAD_TEXT;
            end
            p_pcnt = p_pcnt + 32'd1;
            if (r.status == ST_OK && p_pcnt == p_len) begin
                if (p_first[3:0] == OP_CLOSE && p_u8rem != 0) r.status = ST_BAD_TEXT;
                else begin
                    r.frame_done = 1'b1;
                    p_phase = PH_HEADER;
                    p_hcnt = '0;
                end
            end
        end
        if (r.status != ST_OK) begin
            p_err = r.status;
            p_phase = PH_ERROR;
            r.frame_done = 1'b0;
        end
        r.frame_opcode = p_first[3:0];
        r.final_flag = p_first[7];
        r.compressed_flag = p_first[6];
        r.frame_length = len_ready ? p_len : 32'd0;
        r.close_code = (p_first[3:0] == OP_CLOSE && p_pcnt >= 2) ? p_ccode : 16'd0;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s got %0h want %0h", $time, field, got, want);
        mismatches++;
    endtask

    // result side: pop the oldest expectation per accepted word
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_results.size() == 0) report_mismatch("unexpected word", 32'd0, 32'd0);
            else begin
                want = pending_results.pop_front();
                if (res_if.kind != want.kind)
                    report_mismatch("kind", 32'(res_if.kind), 32'(want.kind));
                if (res_if.payload_byte != want.payload_byte)
                    report_mismatch("payload_byte", 32'(res_if.payload_byte),
                                    32'(want.payload_byte));
                if (res_if.payload_offset != want.payload_offset)
                    report_mismatch("payload_offset", res_if.payload_offset, want.payload_offset);
                if (res_if.frame_done != want.frame_done)
                    report_mismatch("frame_done", 32'(res_if.frame_done), 32'(want.frame_done));
                if (res_if.status != want.status)
                    report_mismatch("status", 32'(res_if.status), 32'(want.status));
                if (res_if.frame_opcode != want.frame_opcode)
                    report_mismatch("frame_opcode", 32'(res_if.frame_opcode),
                                    32'(want.frame_opcode));
                if (res_if.final_flag != want.final_flag)
                    report_mismatch("final_flag", 32'(res_if.final_flag), 32'(want.final_flag));
                if (res_if.compressed_flag != want.compressed_flag)
                    report_mismatch("compressed_flag", 32'(res_if.compressed_flag),
                                    32'(want.compressed_flag));
                if (res_if.frame_length != want.frame_length)
                    report_mismatch("frame_length", res_if.frame_length, want.frame_length);
                if (res_if.close_code != want.close_code)
                    report_mismatch("close_code", 32'(res_if.close_code), 32'(want.close_code));
            end
        end
    end

    // sink stalls in random bursts, none in the quiet tail
    int stall_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b1;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            res_if.ready <= (stall_left == 1);
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall_left <= int'($urandom_range(1, 8));
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    // one stream word; expectation pushed at acceptance
    task automatic send_byte(input logic [7:0] b, input bit typed, input t_result typed_res);
        t_result r;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            data_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        data_if.valid <= 1'b1;
        data_if.data_byte <= b;
        @(posedge i_clk);
        while (!data_if.ready) @(posedge i_clk);
        r = deframe_byte(b);
        pending_results.push_back(typed ? typed_res : r);
    endtask

    task automatic send_stream(ref logic [7:0] q[$]);
        foreach (q[i]) send_byte(q[i], 1'b0, '0);
    endtask

    task automatic write_deflate(input logic v);
        data_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        // let the bus settle before the write
        repeat (4) @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.deflate_allowed <= v;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        p_deflate = v;
    endtask

    // appends a masked frame; lsel 0 short length, 1 16-bit, 2 64-bit
    task automatic put_frame(ref logic [7:0] q[$], input logic [7:0] b0,
                             ref logic [7:0] body[$], input int lsel);
        logic [31:0] key;
        longint      n;
        n = body.size();
        key = $urandom;
        q.push_back(b0);
        if (lsel == 0) q.push_back(8'h80 | {1'b0, n[6:0]});
        else if (lsel == 1) begin
            q.push_back(8'hFE);
            for (int i = 1; i >= 0; i--) q.push_back(n[8*i +: 8]);
        end else begin
            q.push_back(8'hFF);
            for (int i = 7; i >= 0; i--) q.push_back(n[8*i +: 8]);
        end
        for (int i = 3; i >= 0; i--) q.push_back(key[8*i +: 8]);
        foreach (body[i]) q.push_back(body[i] ^ key[8*(3 - i % 4) +: 8]);
    endtask

    task automatic put_utf8_char(ref logic [7:0] q[$]);
        case ($urandom_range(0, 7))
            0: q.push_back(8'($urandom_range(8'h00, 8'h7F)));
            1: begin
                q.push_back(8'($urandom_range(8'hC2, 8'hDF)));
                q.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end
            2: begin
                q.push_back(8'hE0);
                q.push_back(8'($urandom_range(8'hA0, 8'hBF)));
                q.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end
            3: begin
                q.push_back(8'hED);
                q.push_back(8'($urandom_range(8'h80, 8'h9F)));
                q.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end
            4: begin
                q.push_back(8'($urandom_range(0, 1) ? $urandom_range(8'hE1, 8'hEC)
                                                    : $urandom_range(8'hEE, 8'hEF)));
                q.push_back(8'($urandom_range(8'h80, 8'hBF)));
                q.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end
            5: begin
                q.push_back(8'hF0);
                q.push_back(8'($urandom_range(8'h90, 8'hBF)));
                repeat (2) q.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end
            6: begin
                q.push_back(8'($urandom_range(8'hF1, 8'hF3)));
                repeat (3) q.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end
            default: begin
                q.push_back(8'hF4);
                q.push_back(8'($urandom_range(8'h80, 8'h8F)));
                repeat (2) q.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end
        endcase
    endtask

    function automatic logic [15:0] pick_close_code();
        case ($urandom_range(0, 2))
            0: return 16'($urandom_range(1000, 1003));
            1: return 16'($urandom_range(1007, 1011));
            default: return 16'($urandom_range(3000, 4999));
        endcase
    endfunction

    // well-formed frame with random content
    task automatic put_good_frame(ref logic [7:0] q[$]);
        logic [7:0] body[$];
        logic [7:0] b0;
        logic [15:0] code;
        int         sel, n, lsel;
        sel = $urandom_range(0, 9);
        lsel = 0;
        if (sel < 2) begin
            b0 = {4'b1000, OP_CLOSE};
            if ($urandom_range(0, 3) != 0) begin
                code = pick_close_code();
                body.push_back(code[15:8]);
                body.push_back(code[7:0]);
                n = $urandom_range(0, 5);
                repeat (n) put_utf8_char(body);
            end
        end else if (sel == 2) begin
            b0 = {4'b1000, $urandom_range(0, 1) ? OP_PING : OP_PONG};
            n = ($urandom_range(0, 15) == 0) ? 125 : $urandom_range(0, 10);
            repeat (n) body.push_back(8'($urandom));
        end else begin
            b0[7] = 1'($urandom);
            b0[6] = p_deflate ? 1'($urandom) : 1'b0;
            b0[5:4] = 2'b00;
            b0[3:0] = 4'($urandom_range(0, 2));
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(0, 12);
            repeat (n) body.push_back(8'($urandom));
            lsel = (n > 125) ? $urandom_range(1, 2) : $urandom_range(0, 5) / 4;
        end
        put_frame(q, b0, body, lsel);
    endtask

    // one error case, sticky until the end of the run
    task automatic put_bad_frame(ref logic [7:0] q[$]);
        logic [7:0] body[$];
        logic [31:0] key;
        case ($urandom_range(0, 9))
            0: put_frame(q, 8'(8'h83 + $urandom_range(0, 4)), body, 0);   // reserved opcode
            1: put_frame(q, {4'b0000, OP_PING}, body, 0);                // control without fin
            2: put_frame(q, 8'(8'h81 | ($urandom_range(1, 3) << 4)), body, 0);
            3: put_frame(q, 8'hC1, body, 0);                             // rsv1, deflate off
            4: begin                                                     // unmasked
                q.push_back(8'h82);
                q.push_back(8'h03);
            end
            5: begin                                                     // length too large
                q.push_back(8'h82);
                q.push_back(8'hFF);
                repeat (3) q.push_back(8'h00);
                q.push_back(8'($urandom_range(1, 255)));
                repeat (4) q.push_back(8'($urandom));
                key = $urandom;
                for (int i = 3; i >= 0; i--) q.push_back(key[8*i +: 8]);
            end
            6: begin                                                     // close of length one
                body.push_back(8'h03);
                put_frame(q, {4'b1000, OP_CLOSE}, body, 0);
            end
            7: begin                                                     // bad close code
                body.push_back(8'h03);
                body.push_back(8'hE7);
                put_frame(q, {4'b1000, OP_CLOSE}, body, 0);
            end
            8: begin                                                     // invalid reason byte
                body.push_back(8'h03);
                body.push_back(8'hE8);
                body.push_back(8'hFF);
                put_frame(q, {4'b1000, OP_CLOSE}, body, 0);
            end
            default: begin                                               // reason cut short
                body.push_back(8'h03);
                body.push_back(8'hE8);
                body.push_back(8'hE2);
                body.push_back(8'h82);
                put_frame(q, {4'b1000, OP_CLOSE}, body, 0);
            end
        endcase
    endtask

    typedef struct {
        logic [7:0] stream_byte;
        bit         typed;
        t_result    res;
    } t_row;

    initial begin
        t_row       rows[$];
        logic [7:0] q[$];
        t_result    t;
        int         sent;
        data_if.valid = 1'b0;
        data_if.data_byte = '0;
        cfg_if.valid = 1'b0;
        cfg_if.deflate_allowed = 1'b0;
        i_rst_n = 1'b0;
        mismatches = 0;
        quiet = 1'b0;
        p_phase = PH_HEADER; p_hcnt = '0; p_first = '0; p_lcode = '0; p_len = '0;
        p_ovf = 1'b0; p_key = '0; p_pcnt = '0; p_ccode = '0; p_u8rem = '0;
        p_u8lim = U8_NONE; p_err = ST_OK; p_deflate = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty text frame, all-ones key; its first and last header words are typed in
        t = '0; t.kind = KIND_HEADER; t.frame_opcode = OP_TEXT; t.final_flag = 1'b1;
        rows.push_back('{8'h81, 1'b1, t});
        rows.push_back('{8'h80, 1'b0, '0});
        repeat (3) rows.push_back('{8'hFF, 1'b0, '0});
        t.frame_done = 1'b1;
        rows.push_back('{8'hFF, 1'b1, t});
        // close with code 1000, zero key
        rows.push_back('{8'h88, 1'b0, '0});
        rows.push_back('{8'h82, 1'b0, '0});
        repeat (4) rows.push_back('{8'h00, 1'b0, '0});
        rows.push_back('{8'h03, 1'b0, '0});
        rows.push_back('{8'hE8, 1'b0, '0});
        // binary, 16-bit length code carrying 3
        rows.push_back('{8'h02, 1'b0, '0});
        rows.push_back('{8'hFE, 1'b0, '0});
        rows.push_back('{8'h00, 1'b0, '0});
        rows.push_back('{8'h03, 1'b0, '0});
        rows.push_back('{8'h5A, 1'b0, '0});
        rows.push_back('{8'hA5, 1'b0, '0});
        rows.push_back('{8'h0F, 1'b0, '0});
        rows.push_back('{8'hF0, 1'b0, '0});
        rows.push_back('{8'h00, 1'b0, '0});
        rows.push_back('{8'hFF, 1'b0, '0});
        rows.push_back('{8'h80, 1'b0, '0});
        foreach (rows[i]) send_byte(rows[i].stream_byte, rows[i].typed, rows[i].res);

        write_deflate(1'b1);
        sent = 0;
        while (sent < 800) begin
            q.delete();
            put_good_frame(q);
            send_stream(q);
            sent += q.size();
        end
        write_deflate(1'b0);
        while (sent < 1650) begin
            q.delete();
            put_good_frame(q);
            if (sent > 1400) quiet = 1'b1;
            send_stream(q);
            sent += q.size();
        end
        q.delete();
        put_bad_frame(q);
        repeat (30) q.push_back(8'($urandom));
        send_stream(q);

        data_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+sv
sv/wsfd_pkg.sv
sv/wsfd_ifs.sv
sv/wsfd_front.sv
sv/wsfd_back.sv
sv/websocket_frame_deframer_top.sv
tb/sv/tb_top.sv
